// ----- design/nearest_calibration_offset_table_core_assert.svh -----
// Assertion macros for the calibration offset table core.
`ifndef NEAREST_CALIBRATION_OFFSET_TABLE_CORE_ASSERT_SVH
`define NEAREST_CALIBRATION_OFFSET_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, checked on the rising edge of clk outside of reset.
`define NCOT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside of reset.
`define NCOT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/ncot_pkg.sv -----
// Package with the sizes, codes and types of the calibration offset table.
`timescale 1ns / 1ps
package ncot_pkg;
	localparam int FREQ_SLOTS  = 16;
	localparam int POWER_SLOTS = 16;

	localparam int FREQ_W     = 34;
	localparam int POWER_W    = 20;
	localparam int OFS_W      = 16;
	localparam int CMD_W      = 2;
	localparam int STAT_W     = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 34;
	localparam int KEY_W      = FREQ_W + 1;

	localparam int MAX_SLOTS = (FREQ_SLOTS > POWER_SLOTS) ? FREQ_SLOTS : POWER_SLOTS;
	localparam int FIDX_W    = (FREQ_SLOTS > 1) ? $clog2(FREQ_SLOTS) : 1;
	localparam int PIDX_W    = (POWER_SLOTS > 1) ? $clog2(POWER_SLOTS) : 1;
	localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
	localparam int MEM_DEPTH = FREQ_SLOTS * POWER_SLOTS;
	localparam int PADDR_W   = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	typedef logic [CMD_W-1:0] cmd_t;
	localparam cmd_t CMD_LOOKUP = 2'd0;
	localparam cmd_t CMD_SET    = 2'd1;
	localparam cmd_t CMD_CLEAR  = 2'd2;

	typedef logic [STAT_W-1:0] status_t;
	localparam status_t STAT_OK       = 2'd0;
	localparam status_t STAT_NO_MATCH = 2'd1;
	localparam status_t STAT_FULL     = 2'd2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_FREQ_LIMIT  = 1'd0;
	localparam cfg_idx_t REG_POWER_LIMIT = 1'd1;

	typedef logic [FREQ_W-1:0] freq_t;
	typedef logic signed [POWER_W-1:0] power_t;
	typedef logic signed [OFS_W-1:0] ofs_t;

	localparam freq_t FREQ_LIMIT_RST = 34'd10000000000;
	localparam logic [POWER_W-1:0] POWER_LIMIT_RST = 20'd256000;
endpackage

// ----- design/ncot_chan_if.sv -----
// Valid/ready channel interfaces for the request and response sides.
`timescale 1ns / 1ps
interface ncot_in_if;
	import ncot_pkg::*;
	logic   valid;
	logic   ready;
	cmd_t   command;
	freq_t  frequency_hz;
	power_t power_level;
	ofs_t   offset_value;

	modport source(output valid, output command, output frequency_hz, output power_level,
		output offset_value, input ready);
	modport sink(input valid, input command, input frequency_hz, input power_level,
		input offset_value, output ready);
endinterface

interface ncot_out_if;
	import ncot_pkg::*;
	logic    valid;
	logic    ready;
	ofs_t    offset_result;
	status_t status;

	modport source(output valid, output offset_result, output status, input ready);
	modport sink(input valid, input offset_result, input status, output ready);
endinterface

// ----- design/nearest_calibration_offset_table_core.sv -----
// Two-level nearest-key calibration offset table with a sequential slot scan.
//
//  Channel  Direction  Carries
//  req      in         command, frequency_hz, power_level, offset_value
//  rsp      out        offset_result, status
//  cfg      in         cfg_wen, cfg_index, cfg_data (limit registers)
//
// A lookup or set scans the frequency slots and, when one of them matches, one row of power
// slots through one shared distance and compare unit, one slot per cycle.
// Lookup and set pass through the finish state after the scans, clear goes straight to it,
// and the next transaction is taken once the block is back in the idle state.
// The block takes one transaction at a time and holds req.ready low while it works.
// A finished result waits in the output register; while it is held, the next result
// waits in the finish state and req.ready stays low.
// Reset clears all valid bits at once, so no clearing pass is needed.
`timescale 1ns / 1ps
`include "nearest_calibration_offset_table_core_assert.svh"
module nearest_calibration_offset_table_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  ncot_pkg::cfg_idx_t              cfg_index,
	input  logic [ncot_pkg::CFG_DATA_W-1:0] cfg_data,
	ncot_in_if.sink                         req,
	ncot_out_if.source                      rsp
);
	import ncot_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_FSCAN = 2'd1;
	localparam logic [1:0] ST_PSCAN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0] state_q;
	cmd_t       cmd_q;
	freq_t      freq_q;
	power_t     power_q;
	ofs_t       ofs_q;

	freq_t              freq_lim_q;
	logic [POWER_W-1:0] power_lim_q;

	freq_t                                   fkeys_q [FREQ_SLOTS];
	logic [FREQ_SLOTS-1:0]                   fvalid_q;
	logic [FREQ_SLOTS-1:0][POWER_SLOTS-1:0]  pvalid_q;
	power_t                                  pkey_mem_q [MEM_DEPTH];
	ofs_t                                    ofs_mem_q [MEM_DEPTH];
	logic [FIDX_W-1:0]                       fs_q;

	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   scan_len;
	logic [IDX_W-1:0]   idx;
	logic               scanning;
	logic               issue;
	logic               scan_done;
	logic [PADDR_W-1:0] rd_addr;

	logic               v_s1;
	logic               vld_s1;
	logic [IDX_W-1:0]   idx_s1;
	freq_t              fkey_rd_s1;
	power_t             pkey_rd_s1;
	ofs_t               ofs_rd_s1;
	logic signed [KEY_W-1:0] key_s1;
	logic signed [KEY_W-1:0] req_key;
	logic signed [KEY_W-1:0] diff;
	logic signed [KEY_W-1:0] neg_diff;
	freq_t              key_dist;

	logic               v_s2;
	logic               vld_s2;
	logic [IDX_W-1:0]   idx_s2;
	logic signed [KEY_W-1:0] key_s2;
	freq_t              dist_s2;
	ofs_t               ofs_s2;

	logic               hit_q;
	logic               free_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [IDX_W-1:0]   free_idx_q;
	freq_t              best_dist_q;
	logic signed [KEY_W-1:0] best_key_q;
	ofs_t               best_ofs_q;

	freq_t              lim;
	logic               in_limit;
	logic               better;
	logic               take_best;
	logic               take_match;
	logic               take_free;

	logic               key_we;
	logic               ofs_we;
	logic               fkey_we;
	logic [FIDX_W-1:0]  wr_row;
	logic [PIDX_W-1:0]  wr_col;
	logic [PADDR_W-1:0] wr_addr;

	ofs_t               fin_ofs_d;
	status_t            fin_st_d;
	ofs_t               fin_ofs_q;
	status_t            fin_st_q;
	logic               out_valid_q;
	ofs_t               out_ofs_q;
	status_t            out_st_q;
	logic               in_take;
	logic               out_load;

	assign req.ready         = (state_q == ST_IDLE);
	assign in_take           = req.valid && req.ready;
	assign rsp.valid         = out_valid_q;
	assign rsp.offset_result = out_ofs_q;
	assign rsp.status        = out_st_q;
	assign out_load          = (state_q == ST_FIN) && (!out_valid_q || rsp.ready);

	assign scanning  = (state_q == ST_FSCAN) || (state_q == ST_PSCAN);
	assign scan_len  = (state_q == ST_PSCAN) ? CNT_W'(POWER_SLOTS) : CNT_W'(FREQ_SLOTS);
	assign issue     = scanning && (cnt_q < scan_len);
	assign idx       = cnt_q[IDX_W-1:0];
	assign scan_done = scanning && (cnt_q == scan_len) && !v_s1 && !v_s2;
	assign rd_addr   = PADDR_W'(fs_q * POWER_SLOTS) + PADDR_W'(idx[PIDX_W-1:0]);

	// Shared distance unit: both key kinds are widened to one signed format.
	always_comb begin
		if (state_q == ST_PSCAN) begin
			key_s1  = {{(KEY_W-POWER_W){pkey_rd_s1[POWER_W-1]}}, pkey_rd_s1};
			req_key = {{(KEY_W-POWER_W){power_q[POWER_W-1]}}, power_q};
			lim     = FREQ_W'(power_lim_q);
		end else begin
			key_s1  = {1'b0, fkey_rd_s1};
			req_key = {1'b0, freq_q};
			lim     = freq_lim_q;
		end
		diff     = req_key - key_s1;
		neg_diff = -diff;
		key_dist = diff[KEY_W-1] ? neg_diff[FREQ_W-1:0] : diff[FREQ_W-1:0];
	end

	always_comb begin
		in_limit   = (dist_s2 == '0) || (dist_s2 < lim);
		better     = !hit_q || (dist_s2 < best_dist_q)
			|| ((dist_s2 == best_dist_q) && (key_s2 < best_key_q));
		take_best  = v_s2 && vld_s2 && (cmd_q == CMD_LOOKUP) && in_limit && better;
		take_match = v_s2 && vld_s2 && (cmd_q == CMD_SET) && (dist_s2 == '0) && !hit_q;
		take_free  = v_s2 && !vld_s2 && (cmd_q == CMD_SET) && !free_q;
	end

	always_comb begin
		fin_ofs_d = '0;
		fin_st_d  = STAT_OK;
		if (cmd_q == CMD_LOOKUP) begin
			if (!hit_q) begin
				fin_st_d = STAT_NO_MATCH;
			end else if (state_q == ST_PSCAN) begin
				fin_ofs_d = best_ofs_q;
			end
		end else if (!hit_q && !free_q) begin
			fin_st_d = STAT_FULL;
		end
	end

	always_comb begin
		key_we  = 1'b0;
		ofs_we  = 1'b0;
		fkey_we = 1'b0;
		wr_row  = fs_q;
		wr_col  = '0;
		if (scan_done && (cmd_q == CMD_SET)) begin
			if ((state_q == ST_FSCAN) && !hit_q && free_q) begin
				fkey_we = 1'b1;
				key_we  = 1'b1;
				ofs_we  = 1'b1;
				wr_row  = free_idx_q[FIDX_W-1:0];
			end else if (state_q == ST_PSCAN) begin
				if (hit_q) begin
					ofs_we = 1'b1;
					wr_col = best_idx_q[PIDX_W-1:0];
				end else if (free_q) begin
					key_we = 1'b1;
					ofs_we = 1'b1;
					wr_col = free_idx_q[PIDX_W-1:0];
				end
			end
		end
		wr_addr = PADDR_W'(wr_row * POWER_SLOTS) + PADDR_W'(wr_col);
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			pkey_mem_q[wr_addr] <= power_q;
		end
		if (ofs_we) begin
			ofs_mem_q[wr_addr] <= ofs_q;
		end
		if (fkey_we) begin
			fkeys_q[wr_row] <= freq_q;
		end
		pkey_rd_s1 <= pkey_mem_q[rd_addr];
		ofs_rd_s1  <= ofs_mem_q[rd_addr];
		fkey_rd_s1 <= fkeys_q[idx[FIDX_W-1:0]];
		idx_s1     <= idx;
		idx_s2     <= idx_s1;
		key_s2     <= key_s1;
		dist_s2    <= key_dist;
		ofs_s2     <= ofs_rd_s1;
		if (take_best || take_match) begin
			best_idx_q  <= idx_s2;
			best_dist_q <= dist_s2;
			best_key_q  <= key_s2;
			best_ofs_q  <= ofs_s2;
		end
		if (take_free) begin
			free_idx_q <= idx_s2;
		end
		if (in_take) begin
			cmd_q     <= req.command;
			freq_q    <= req.frequency_hz;
			power_q   <= req.power_level;
			ofs_q     <= req.offset_value;
			fin_ofs_q <= '0;
			fin_st_q  <= STAT_OK;
		end
		if (scan_done) begin
			fin_ofs_q <= fin_ofs_d;
			fin_st_q  <= fin_st_d;
			if (state_q == ST_FSCAN) begin
				fs_q <= hit_q ? best_idx_q[FIDX_W-1:0] : free_idx_q[FIDX_W-1:0];
			end
		end
		if (out_load) begin
			out_ofs_q <= fin_ofs_q;
			out_st_q  <= fin_st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			fvalid_q    <= '0;
			pvalid_q    <= '0;
			out_valid_q <= 1'b0;
			freq_lim_q  <= FREQ_LIMIT_RST;
			power_lim_q <= POWER_LIMIT_RST;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_index)
					REG_FREQ_LIMIT: begin
						freq_lim_q <= cfg_data[FREQ_W-1:0];
					end
					REG_POWER_LIMIT: begin
						power_lim_q <= cfg_data[POWER_W-1:0];
					end
				endcase
			end

			v_s1   <= issue;
			v_s2   <= v_s1;
			vld_s1 <= (state_q == ST_PSCAN) ? pvalid_q[fs_q][idx[PIDX_W-1:0]]
				: fvalid_q[idx[FIDX_W-1:0]];
			vld_s2 <= vld_s1;
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (take_best || take_match) begin
				hit_q <= 1'b1;
			end
			if (take_free) begin
				free_q <= 1'b1;
			end

			if (rsp.valid && rsp.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						case (req.command) inside
							CMD_LOOKUP, CMD_SET: begin
								state_q <= ST_FSCAN;
								cnt_q   <= '0;
								hit_q   <= 1'b0;
								free_q  <= 1'b0;
							end
							CMD_CLEAR: begin
								fvalid_q <= '0;
								pvalid_q <= '0;
								state_q  <= ST_FIN;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_FSCAN: begin
					if (scan_done) begin
						if (hit_q) begin
							state_q <= ST_PSCAN;
							cnt_q   <= '0;
							hit_q   <= 1'b0;
							free_q  <= 1'b0;
						end else begin
							state_q <= ST_FIN;
							if ((cmd_q == CMD_SET) && free_q) begin
								fvalid_q[free_idx_q[FIDX_W-1:0]] <= 1'b1;
								pvalid_q[free_idx_q[FIDX_W-1:0]] <= POWER_SLOTS'(1);
							end
						end
					end
				end
				ST_PSCAN: begin
					if (scan_done) begin
						state_q <= ST_FIN;
						if ((cmd_q == CMD_SET) && !hit_q && free_q) begin
							pvalid_q[fs_q][free_idx_q[PIDX_W-1:0]] <= 1'b1;
						end
					end
				end
				ST_FIN: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`NCOT_ASSERT_NXT(a_accept_leaves_idle, in_take, state_q != ST_IDLE, "accepted transaction left the block idle")
	`NCOT_ASSERT_IMP(a_pscan_row_valid, state_q == ST_PSCAN, fvalid_q[fs_q], "power scan on an empty frequency slot")
	`NCOT_ASSERT_IMP(a_miss_zero_offset, out_valid_q && (out_st_q != STAT_OK), out_ofs_q == '0, "failed transaction carries a nonzero offset")
	`NCOT_ASSERT_IMP(a_scan_count_bound, scanning, cnt_q <= scan_len, "scan counter ran past the slot count")
endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the two-level nearest-key calibration offset table core.
`timescale 1ns / 1ps
module testbench;
	import ncot_pkg::*;

	localparam int BLOCK_LATENCY  = FREQ_SLOTS + POWER_SLOTS + 9;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 400;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 178;
	localparam int POOL_SIZE      = 20;
	localparam int BURST_LEN      = 18;

	localparam cmd_t   CMD_UNUSED = 2'd3;
	localparam freq_t  FREQ_MAX   = '1;
	localparam power_t POWER_MIN  = 20'sh80000;
	localparam power_t POWER_MAX  = 20'sh7FFFF;
	localparam ofs_t   OFS_MIN    = 16'sh8000;
	localparam ofs_t   OFS_MAX    = 16'sh7FFF;
	localparam longint unsigned FREQ_LIMIT_MAX  = 64'h3_FFFF_FFFF;
	localparam longint unsigned POWER_LIMIT_MAX = 64'hF_FFFF;

	typedef struct {
		cmd_t   command;
		freq_t  freq;
		power_t power;
		ofs_t   offset;
	} table_req_t;

	typedef struct {
		ofs_t    offset;
		status_t status;
	} table_reply_t;

	typedef struct {
		bit              is_limit;
		cfg_idx_t        reg_idx;
		longint unsigned reg_value;
		table_req_t      req;
		bit              typed;
		table_reply_t    want;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wen;
	cfg_idx_t cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ncot_in_if  req_if();
	ncot_out_if rsp_if();

	nearest_calibration_offset_table_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_if),
		.rsp(rsp_if)
	);

	always #10 clk = ~clk;

	freq_t  cal_freq_key[FREQ_SLOTS];
	bit     cal_freq_used[FREQ_SLOTS];
	power_t cal_power_key[MEM_DEPTH];
	bit     cal_power_used[MEM_DEPTH];
	ofs_t   cal_offset[MEM_DEPTH];
	longint unsigned freq_limit;
	longint unsigned power_limit;

	table_reply_t  awaited_replies[$];
	table_reply_t  head_reply;
	directed_row_t directed_rows[$];
	int error_count = 0;
	int stall_cycles = 0;
	int no_gap_left = 0;
	bit hold_output = 1'b0;

	freq_t  freq_pool[POOL_SIZE];
	power_t power_pool[POOL_SIZE];
	int unsigned key_span;
	int unsigned power_span;

	function automatic void clear_table();
		foreach (cal_freq_used[i]) cal_freq_used[i] = 1'b0;
		foreach (cal_power_used[i]) cal_power_used[i] = 1'b0;
	endfunction

	function automatic bit store_offset(freq_t f, power_t p, ofs_t o);
		int fs = -1;
		int ffree = -1;
		int ps = -1;
		int pfree = -1;
		int k;
		for (int i = 0; i < FREQ_SLOTS; i++) begin
			if (cal_freq_used[i]) begin
				if (fs < 0 && cal_freq_key[i] == f) fs = i;
			end else if (ffree < 0) begin
				ffree = i;
			end
		end
		if (fs < 0) begin
			if (ffree < 0) return 1'b0;
			fs = ffree;
			cal_freq_key[fs] = f;
			cal_freq_used[fs] = 1'b1;
			for (int i = 0; i < POWER_SLOTS; i++) cal_power_used[fs * POWER_SLOTS + i] = 1'b0;
		end
		for (int i = 0; i < POWER_SLOTS; i++) begin
			k = fs * POWER_SLOTS + i;
			if (cal_power_used[k]) begin
				if (ps < 0 && cal_power_key[k] == p) ps = k;
			end else if (pfree < 0) begin
				pfree = k;
			end
		end
		if (ps < 0) begin
			if (pfree < 0) return 1'b0;
			ps = pfree;
			cal_power_key[ps] = p;
			cal_power_used[ps] = 1'b1;
		end
		cal_offset[ps] = o;
		return 1'b1;
	endfunction

	function automatic bit find_offset(input freq_t f, input power_t p, output ofs_t found);
		int fs = -1;
		int ps = -1;
		int k;
		longint unsigned d;
		longint unsigned best = 0;
		longint pa;
		longint pb;
		found = '0;
		for (int i = 0; i < FREQ_SLOTS; i++) begin
			if (!cal_freq_used[i]) continue;
			d = (f > cal_freq_key[i]) ? f - cal_freq_key[i] : cal_freq_key[i] - f;
			if (d != 0 && d >= freq_limit) continue;
			if (fs < 0 || d < best || (d == best && cal_freq_key[i] < cal_freq_key[fs])) begin
				fs = i;
				best = d;
			end
		end
		if (fs < 0) return 1'b0;
		pa = p;
		for (int i = 0; i < POWER_SLOTS; i++) begin
			k = fs * POWER_SLOTS + i;
			if (!cal_power_used[k]) continue;
			pb = cal_power_key[k];
			d = (pa > pb) ? pa - pb : pb - pa;
			if (d != 0 && d >= power_limit) continue;
			if (ps < 0 || d < best || (d == best && cal_power_key[k] < cal_power_key[ps])) begin
				ps = k;
				best = d;
			end
		end
		if (ps < 0) return 1'b0;
		found = cal_offset[ps];
		return 1'b1;
	endfunction

	function automatic table_reply_t apply_table_command(table_req_t r);
		table_reply_t reply;
		ofs_t found;
		reply.offset = '0;
		reply.status = STAT_OK;
		case (r.command)
			CMD_LOOKUP: begin
				if (find_offset(r.freq, r.power, found)) reply.offset = found;
				else reply.status = STAT_NO_MATCH;
			end
			CMD_SET: begin
				if (!store_offset(r.freq, r.power, r.offset)) reply.status = STAT_FULL;
			end
			CMD_CLEAR: clear_table();
			default: ;
		endcase
		return reply;
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_gap_left > 0) begin
			no_gap_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			no_gap_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	function automatic freq_t pick_freq();
		int r;
		freq_t base;
		r = $urandom_range(0, 99);
		base = freq_pool[$urandom_range(0, POOL_SIZE - 1)];
		if (r < 70) return base;
		if (r < 90) return base + freq_t'($urandom_range(0, key_span / 4)) - freq_t'(key_span / 8);
		return freq_t'({$urandom(), $urandom()});
	endfunction

	function automatic power_t pick_power();
		int r;
		power_t base;
		r = $urandom_range(0, 99);
		base = power_pool[$urandom_range(0, POOL_SIZE - 1)];
		if (r < 70) return base;
		if (r < 90) return base + power_t'($urandom_range(0, power_span / 4))
			- power_t'(power_span / 8);
		return power_t'($urandom());
	endfunction

	function automatic void add_item(cmd_t c, freq_t f, power_t p, ofs_t o);
		directed_row_t row;
		row.is_limit = 1'b0;
		row.reg_idx = REG_FREQ_LIMIT;
		row.reg_value = 0;
		row.req = '{c, f, p, o};
		row.typed = 1'b0;
		row.want = '{'0, STAT_OK};
		directed_rows.push_back(row);
	endfunction

	function automatic void add_checked(cmd_t c, freq_t f, power_t p, ofs_t o, ofs_t w_ofs,
		status_t w_stat);
		add_item(c, f, p, o);
		directed_rows[$].typed = 1'b1;
		directed_rows[$].want = '{w_ofs, w_stat};
	endfunction

	function automatic void add_limit(cfg_idx_t idx, longint unsigned value);
		add_item(CMD_LOOKUP, '0, '0, '0);
		directed_rows[$].is_limit = 1'b1;
		directed_rows[$].reg_idx = idx;
		directed_rows[$].reg_value = value;
	endfunction

	task automatic send_request(table_req_t r, bit typed, table_reply_t want);
		int gap;
		table_reply_t predicted;
		gap = pick_gap();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.command <= r.command;
		req_if.frequency_hz <= r.freq;
		req_if.power_level <= r.power;
		req_if.offset_value <= r.offset;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		predicted = apply_table_command(r);
		awaited_replies.push_back(typed ? want : predicted);
	endtask

	task automatic issue(cmd_t c, freq_t f, power_t p, ofs_t o);
		table_req_t r;
		table_reply_t none;
		r = '{c, f, p, o};
		none = '{'0, STAT_OK};
		send_request(r, 1'b0, none);
	endtask

	task automatic drain_results();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (awaited_replies.size() != 0);
		repeat (BLOCK_LATENCY) @(posedge clk);
	endtask

	task automatic write_limit(cfg_idx_t idx, longint unsigned value);
		drain_results();
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_wen <= 1'b0;
		if (idx == REG_FREQ_LIMIT) freq_limit = value;
		else power_limit = value;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (awaited_replies.size() == 0) begin
					$display("%0t: unexpected transaction, offset_result %0d status %0d", $time,
						rsp_if.offset_result, rsp_if.status);
					error_count++;
				end else begin
					head_reply = awaited_replies.pop_front();
					if (rsp_if.offset_result !== head_reply.offset) begin
						$display("%0t: offset_result expected %0d actual %0d", $time,
							head_reply.offset, rsp_if.offset_result);
						error_count++;
					end
					if (rsp_if.status !== head_reply.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							head_reply.status, rsp_if.status);
						error_count++;
					end
				end
			end
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin : receiver
		int r;
		int run;
		bit level;
		rsp_if.ready <= 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (hold_output) begin
				rsp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_output = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					level = 1'b1;
					run = $urandom_range(1, 8);
				end else if (r < 70) begin
					level = 1'b1;
					run = $urandom_range(30, 120);
				end else if (r < 95) begin
					level = 1'b0;
					run = $urandom_range(1, 3);
				end else begin
					level = 1'b0;
					run = $urandom_range(10, 40);
				end
				rsp_if.ready <= level;
				repeat (run) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		directed_row_t row;
		int sent;
		int r;
		freq_t f;
		power_t p;
		longint unsigned fl;
		longint unsigned pl;

		arst_n <= 1'b0;
		cfg_wen <= 1'b0;
		cfg_index <= REG_FREQ_LIMIT;
		cfg_data <= '0;
		req_if.valid <= 1'b0;
		req_if.command <= CMD_LOOKUP;
		req_if.frequency_hz <= '0;
		req_if.power_level <= '0;
		req_if.offset_value <= '0;
		freq_limit = FREQ_LIMIT_RST;
		power_limit = POWER_LIMIT_RST;
		clear_table();

		add_checked(CMD_LOOKUP, 5, 0, 0, 0, STAT_NO_MATCH);
		add_checked(CMD_UNUSED, FREQ_MAX, -1, -1, 0, STAT_OK);
		add_checked(CMD_SET, 0, POWER_MIN, OFS_MIN, 0, STAT_OK);
		add_checked(CMD_LOOKUP, 0, POWER_MIN, 0, OFS_MIN, STAT_OK);
		add_checked(CMD_SET, FREQ_MAX, POWER_MAX, OFS_MAX, 0, STAT_OK);
		add_checked(CMD_LOOKUP, FREQ_MAX, POWER_MAX, 0, OFS_MAX, STAT_OK);
		add_checked(CMD_SET, 1000, 0, 100, 0, STAT_OK);
		add_checked(CMD_SET, 1000, 0, 200, 0, STAT_OK);
		add_checked(CMD_SET, 3000, 0, 5, 0, STAT_OK);
		add_item(CMD_LOOKUP, 2000, 0, 0);
		add_checked(CMD_SET, 1000, 256, 9, 0, STAT_OK);
		add_item(CMD_LOOKUP, 1000, 128, 0);
		add_item(CMD_LOOKUP, 1000, 300000, 0);
		add_limit(REG_FREQ_LIMIT, 0);
		add_limit(REG_POWER_LIMIT, 0);
		add_checked(CMD_LOOKUP, 1001, 0, 0, 0, STAT_NO_MATCH);
		add_checked(CMD_LOOKUP, 1000, 0, 0, 200, STAT_OK);
		add_checked(CMD_LOOKUP, 1000, 1, 0, 0, STAT_NO_MATCH);
		add_limit(REG_FREQ_LIMIT, FREQ_LIMIT_MAX);
		add_limit(REG_POWER_LIMIT, POWER_LIMIT_MAX);
		add_item(CMD_LOOKUP, 34'h2_0000_0000, -100, 0);
		add_checked(CMD_CLEAR, 1000, 0, 0, 0, STAT_OK);
		add_checked(CMD_LOOKUP, 1000, 0, 0, 0, STAT_NO_MATCH);
		add_checked(CMD_SET, 1000, 0, -5, 0, STAT_OK);
		add_item(CMD_LOOKUP, 7, 7, 0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.is_limit) write_limit(row.reg_idx, row.reg_value);
			else send_request(row.req, row.typed, row.want);
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			key_span = 1 << $urandom_range(4, 30);
			power_span = 1 << $urandom_range(2, 18);
			f = freq_t'({$urandom(), $urandom()});
			p = power_t'($urandom());
			foreach (freq_pool[i]) freq_pool[i] = f + freq_t'($urandom_range(0, key_span));
			foreach (power_pool[i]) power_pool[i] = p + power_t'($urandom_range(0, power_span));
			case (phase)
				0: begin
					fl = FREQ_LIMIT_RST;
					pl = POWER_LIMIT_RST;
				end
				1: begin
					fl = 0;
					pl = 0;
				end
				2: begin
					fl = FREQ_LIMIT_MAX;
					pl = POWER_LIMIT_MAX;
				end
				4: begin
					fl = {$urandom(), $urandom()} & FREQ_LIMIT_MAX;
					pl = $urandom_range(0, POWER_LIMIT_MAX);
				end
				5: begin
					fl = 1;
					pl = 1;
				end
				7: begin
					fl = FREQ_LIMIT_RST;
					pl = POWER_LIMIT_RST;
				end
				default: begin
					fl = $urandom_range(0, key_span);
					pl = $urandom_range(0, power_span);
				end
			endcase
			write_limit(REG_FREQ_LIMIT, fl);
			write_limit(REG_POWER_LIMIT, pl);
			// The output side stalls for a long time while the sender keeps pushing.
			if (phase == 2) begin
				hold_output = 1'b1;
				no_gap_left = 40;
			end
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				r = $urandom_range(0, 999);
				if (r < 15) begin
					f = pick_freq();
					p = pick_power();
					for (int k = 0; k < BURST_LEN; k++)
						issue(CMD_SET, f, p + power_t'(k), ofs_t'($urandom()));
					sent += BURST_LEN;
				end else if (r < 25) begin
					for (int k = 0; k < BURST_LEN; k++)
						issue(CMD_SET, freq_t'({$urandom(), $urandom()}), pick_power(),
							ofs_t'($urandom()));
					sent += BURST_LEN;
				end else if (r < 35) begin
					drain_results();
				end else if (r < 55) begin
					issue(CMD_CLEAR, pick_freq(), pick_power(), ofs_t'($urandom()));
					sent++;
				end else if (r < 85) begin
					issue(CMD_UNUSED, pick_freq(), pick_power(), ofs_t'($urandom()));
					sent++;
				end else if (r < 135) begin
					issue(cmd_t'($urandom_range(0, 3)), freq_t'({$urandom(), $urandom()}),
						power_t'($urandom()), ofs_t'($urandom()));
					sent++;
				end else if (r < 570) begin
					issue(CMD_LOOKUP, pick_freq(), pick_power(), ofs_t'($urandom()));
					sent++;
				end else begin
					issue(CMD_SET, pick_freq(), pick_power(), ofs_t'($urandom()));
					sent++;
				end
			end
		end

		drain_results();
		repeat (BLOCK_LATENCY) @(posedge clk);
		if (error_count == 0 && awaited_replies.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+design
design/ncot_pkg.sv
design/ncot_chan_if.sv
design/nearest_calibration_offset_table_core.sv
tb/sv/testbench.sv
